// File: rtl/core/apc_pkg.sv
// Shared types and constants for the axis PID controller.
// No dependencies; imported by apc_mul, apc_div, the top level, the checker and the testbench.
`default_nettype none

package apc_pkg;

  // Q16.16 data word
  localparam int Q_W = 32;
  localparam logic signed [Q_W-1:0] Q_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [Q_W-1:0] Q_MIN = 32'sh8000_0000;

  // shared multiplier: signed operands, magnitude product
  localparam int OP_W   = 34;
  localparam int MAG_W  = 33;
  localparam int PROD_W = 2 * MAG_W;

  // derivative divide: dividend bits, sample period bits, reciprocal accumulator bits
  localparam int DIVD_W = 48;
  localparam int DIVS_W = 16;
  localparam int DACC_W = 79;

  // measurement scale factors 0.95 and 1.05 in Q16.16
  localparam logic [16:0] SCALE_LOW  = 17'd62259;
  localparam logic [16:0] SCALE_HIGH = 17'd68813;

  // period used when the sample period is given as zero
  localparam int FALLBACK_PERIOD = 3000;

  // integrator increment magnitude limit, 2^40
  localparam int INC_W   = 57;
  localparam int INCM_W  = 41;
  localparam logic [INCM_W-1:0] INC_LIMIT = 41'h100_0000_0000;

  // configuration register indexes
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_AXIS_MODE  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PROP_GAIN  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_INT_GAIN   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DERIV_GAIN = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_INTEG_MIN  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_INTEG_MAX  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_DRIVE_MIN  = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_DRIVE_MAX  = 3'd7;

  // axis modes
  localparam logic MODE_ROLL  = 1'b0;
  localparam logic MODE_PITCH = 1'b1;

  // multiplier result: product magnitude plus sign
  typedef struct packed {
    logic              neg;
    logic [PROD_W-1:0] mag;
  } mul_res_t;

endpackage

`default_nettype wire

// File: rtl/core/apc_mul.sv
// Shared two-stage sign-magnitude multiplier for the PID sequencer.
// Depends on apc_pkg. Operands registered, then product registered.
`default_nettype none

module apc_mul
  import apc_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic signed [OP_W-1:0] op_a,
  input  wire logic signed [OP_W-1:0] op_b,
  output mul_res_t                    res
);

  logic [OP_W-1:0]  a_neg_v;
  logic [OP_W-1:0]  b_neg_v;
  logic [MAG_W-1:0] a_mag;
  logic [MAG_W-1:0] b_mag;
  logic [MAG_W-1:0] a_q;
  logic [MAG_W-1:0] b_q;
  logic             neg_q;
  mul_res_t         res_q;

  // operand magnitudes
  assign a_neg_v = -op_a;
  assign b_neg_v = -op_b;
  assign a_mag   = op_a[OP_W-1] ? a_neg_v[MAG_W-1:0] : op_a[MAG_W-1:0];
  assign b_mag   = op_b[OP_W-1] ? b_neg_v[MAG_W-1:0] : op_b[MAG_W-1:0];

  // stage 1: magnitudes and sign
  always_ff @(posedge clk) begin
    a_q   <= a_mag;
    b_q   <= b_mag;
    neg_q <= op_a[OP_W-1] ^ op_b[OP_W-1];
  end

  // stage 2: product
  always_ff @(posedge clk) begin
    res_q.mag <= PROD_W'(a_q) * PROD_W'(b_q);
    res_q.neg <= neg_q;
  end

  assign res = res_q;

endmodule

`default_nettype wire

// File: rtl/core/apc_div.sv
// Reciprocal accumulator for the derivative divide by the sample period.
// Depends on apc_pkg. Sums the four partial products of dividend times ceil(2^63 / T).
`default_nettype none

module apc_div
  import apc_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              load,
  input  wire logic              add,
  input  wire logic              add_hi,
  input  wire logic [PROD_W-1:0] part,
  output logic [DIVD_W-1:0]      quotient
);

  logic [DACC_W-1:0] acc_q;
  logic [DACC_W-1:0] addend;

  // high-by-high partial product sits 32 bits up
  assign addend = add_hi ? {part[DACC_W-33:0], 32'd0} : DACC_W'(part);

  // accumulator holds the full product shifted down by 32
  always_ff @(posedge clk) begin
    if (load) begin
      acc_q <= DACC_W'(part[63:32]);
    end else if (add) begin
      acc_q <= acc_q + addend;
    end
  end

  // the remaining 31 bits of the 2^63 scaling
  assign quotient = acc_q[DACC_W-1:DACC_W-DIVD_W];

endmodule

`default_nettype wire

// File: rtl/core/axis_pid_controller_unit.sv
// Axis PID controller: sequencer, state, configuration registers and output register.
// Depends on apc_pkg, apc_mul (shared multiplier) and apc_div (derivative divider).
//
//  channel   | handshake             | payload
//  ----------+-----------------------+-----------------------------------------
//  request   | req_valid / req_ready | target, sensed (signed Q16.16)
//  response  | rsp_valid / rsp_ready | drive (signed Q16.16), drive_clamped
//  config    | cfg_write             | cfg_index, cfg_data
//
//  Each word takes 18 sequencer steps through the shared two-stage
//  multiplier (the divide by T is four reciprocal partial products), then idle;
//  a new request is taken only in idle. rsp_valid rises as the output register loads.
//  A finished word waits in the output register; a new word may be taken
//  meanwhile, and the sequencer holds in its last step until the register frees.
//  Reset (rst, synchronous) clears configuration registers, rsp_valid, integrator and previous error.
`default_nettype none

module axis_pid_controller_unit
  import apc_pkg::*;
#(
  parameter int SAMPLE_PERIOD = 3000
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  req_valid,
  output logic                       req_ready,
  input  wire logic signed [Q_W-1:0] target,
  input  wire logic signed [Q_W-1:0] sensed,
  output logic                       rsp_valid,
  input  wire logic                  rsp_ready,
  output logic signed [Q_W-1:0]      drive,
  output logic                       drive_clamped,
  input  wire logic                  cfg_write,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [Q_W-1:0]        cfg_data
);

  localparam int T_EFF = (SAMPLE_PERIOD == 0) ? FALLBACK_PERIOD : SAMPLE_PERIOD;
  localparam logic [DIVS_W-1:0] PERIOD = DIVS_W'(T_EFF);
  localparam logic [63:0] DRND = 64'(T_EFF) << 15;
  // ceil(2^63 / T): exact quotient for any dividend below 2^47
  localparam logic [63:0] RECIP = ((64'd1 << 63) + 64'(T_EFF) - 64'd1) / 64'(T_EFF);

  typedef enum logic [18:0] {
    S_IDLE   = 19'h00001,
    S_SCALE  = 19'h00002,
    S_SWAIT  = 19'h00004,
    S_SRND   = 19'h00008,
    S_ERR    = 19'h00010,
    S_MULP   = 19'h00020,
    S_MULI   = 19'h00040,
    S_MULD   = 19'h00080,
    S_QLO    = 19'h00100,
    S_QHI    = 19'h00200,
    S_QREM   = 19'h00400,
    S_INC1   = 19'h00800,
    S_INC2   = 19'h01000,
    S_INC3   = 19'h02000,
    S_INTEG  = 19'h04000,
    S_CLAMPI = 19'h08000,
    S_ADDI   = 19'h10000,
    S_ADDD   = 19'h20000,
    S_CLAMPO = 19'h40000
  } state_t;

  state_t state;

  // configuration
  logic                  axis_mode;
  logic signed [Q_W-1:0] prop_gain;
  logic signed [Q_W-1:0] int_gain;
  logic signed [Q_W-1:0] deriv_gain;
  logic signed [Q_W-1:0] integ_min;
  logic signed [Q_W-1:0] integ_max;
  logic signed [Q_W-1:0] drive_min;
  logic signed [Q_W-1:0] drive_max;

  // controller state
  logic signed [Q_W-1:0] integ_acc;
  logic signed [Q_W-1:0] last_error;

  // working registers
  logic signed [Q_W-1:0]  tgt_q;
  logic signed [Q_W-1:0]  meas_q;
  logic [33:0]            smag_q;
  logic signed [Q_W-1:0]  err_q;
  logic signed [Q_W:0]    sum_q;
  logic signed [Q_W:0]    diff_q;
  logic [47:0]            tmp_q;
  logic                   tmp_neg;
  logic signed [49:0]     acc_q;
  logic [6:0]             qhi_q;
  logic [16:0]            rem17_q;
  logic                   isat_q;
  logic                   ineg_q;
  logic                   dneg_q;
  logic [DIVD_W-1:0]      dnum_q;
  logic [INC_W-1:0]       inc_q;
  logic [16:0]            rr_q;
  logic signed [42:0]     integ_q;
  logic                   rsp_valid_q;
  logic signed [Q_W-1:0]  drive_q;
  logic                   drive_clamped_q;

  // shared units
  logic signed [OP_W-1:0] op_a;
  logic signed [OP_W-1:0] op_b;
  mul_res_t               prod;
  logic                   div_load;
  logic                   div_add;
  logic                   div_add_hi;
  logic [DIVD_W-1:0]      div_quo;

  apc_mul u_mul (
    .clk  (clk),
    .op_a (op_a),
    .op_b (op_b),
    .res  (prod)
  );

  apc_div u_div (
    .clk      (clk),
    .load     (div_load),
    .add      (div_add),
    .add_hi   (div_add_hi),
    .part     (prod.mag),
    .quotient (div_quo)
  );

  // combinational helpers
  logic [49:0]        rnd_scale;
  logic [63:0]        rnd_prop;
  logic [63:0]        rnd_deriv;
  logic [33:0]        rnd_rem;
  logic signed [35:0] err_wide;
  logic signed [Q_W-1:0] err_sat;
  logic               inc_over;
  logic [INCM_W-1:0]  incm;
  logic signed [42:0] integ_inc;
  logic signed [42:0] integ_hi;
  logic signed [42:0] integ_lo;
  logic signed [Q_W-1:0] integ_clamp;
  logic signed [49:0] total;
  logic signed [49:0] out_hi;
  logic signed [49:0] out_lo;
  logic               slot_free;

  assign rnd_scale = prod.mag[49:0] + 50'h8000;
  assign rnd_prop  = prod.mag[63:0] + 64'h8000;
  assign rnd_deriv = prod.mag[63:0] + DRND;
  assign rnd_rem   = prod.mag[33:0] + 34'h1_0000;

  // error: roll scales the measurement, pitch negates the difference
  always_comb begin
    if (axis_mode == MODE_PITCH) begin
      err_wide = 36'(meas_q) - 36'(tgt_q);
    end else if (meas_q[Q_W-1]) begin
      err_wide = 36'(tgt_q) + $signed({2'b00, smag_q});
    end else begin
      err_wide = 36'(tgt_q) - $signed({2'b00, smag_q});
    end
    if (err_wide > 36'(Q_MAX)) begin
      err_sat = Q_MAX;
    end else if (err_wide < 36'(Q_MIN)) begin
      err_sat = Q_MIN;
    end else begin
      err_sat = err_wide[Q_W-1:0];
    end
  end

  // integrator increment, saturated magnitude then signed
  assign inc_over  = isat_q || (inc_q > INC_W'(INC_LIMIT));
  assign incm      = inc_over ? INC_LIMIT : inc_q[INCM_W-1:0];
  assign integ_inc = ineg_q ? -$signed({2'b00, incm}) : $signed({2'b00, incm});

  // integrator clamp, upper test first
  assign integ_hi = 43'(integ_max);
  assign integ_lo = 43'(integ_min);
  always_comb begin
    if (integ_q > integ_hi) begin
      integ_clamp = integ_max;
    end else if (integ_q < integ_lo) begin
      integ_clamp = integ_min;
    end else begin
      integ_clamp = integ_q[Q_W-1:0];
    end
  end

  // output clamp
  assign total  = acc_q;
  assign out_hi = 50'(drive_max);
  assign out_lo = 50'(drive_min);

  assign slot_free = !rsp_valid_q || rsp_ready;

  // multiplier operand select
  always_comb begin
    op_a = '0;
    op_b = '0;
    case (state)
      S_SCALE: begin
        op_a = OP_W'(meas_q);
        op_b = $signed({17'd0, meas_q[Q_W-1] ? SCALE_LOW : SCALE_HIGH});
      end
      S_MULP: begin
        op_a = OP_W'(err_q);
        op_b = OP_W'(prop_gain);
      end
      S_MULI: begin
        op_a = OP_W'(sum_q);
        op_b = OP_W'(int_gain);
      end
      S_MULD: begin
        op_a = OP_W'(diff_q);
        op_b = OP_W'(deriv_gain);
      end
      S_QLO: begin
        op_a = $signed({1'b0, prod.mag[49:17]});
        op_b = $signed({18'd0, PERIOD});
      end
      S_QHI: begin
        op_a = $signed({27'd0, qhi_q});
        op_b = $signed({18'd0, PERIOD});
      end
      S_QREM: begin
        op_a = $signed({17'd0, rem17_q});
        op_b = $signed({18'd0, PERIOD});
      end
      // derivative dividend times reciprocal, low and high halves
      S_INC1: begin
        op_a = $signed({2'b00, dnum_q[31:0]});
        op_b = $signed({2'b00, RECIP[31:0]});
      end
      S_INC2: begin
        op_a = $signed({18'd0, dnum_q[47:32]});
        op_b = $signed({2'b00, RECIP[31:0]});
      end
      S_INC3: begin
        op_a = $signed({2'b00, dnum_q[31:0]});
        op_b = $signed({2'b00, RECIP[63:32]});
      end
      S_INTEG: begin
        op_a = $signed({18'd0, dnum_q[47:32]});
        op_b = $signed({2'b00, RECIP[63:32]});
      end
      default: begin
        op_a = '0;
        op_b = '0;
      end
    endcase
  end

  // (|kd*diff| + T/2 * 2^16) / 2^16 / T, partial products land after the multiplier's operand and product registers
  assign div_load   = (state == S_INC3);
  assign div_add    = (state == S_INTEG) || (state == S_CLAMPI) || (state == S_ADDI);
  assign div_add_hi = (state == S_ADDI);

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      axis_mode  <= MODE_ROLL;
      prop_gain  <= '0;
      int_gain   <= '0;
      deriv_gain <= '0;
      integ_min  <= '0;
      integ_max  <= '0;
      drive_min  <= '0;
      drive_max  <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_AXIS_MODE:  axis_mode  <= cfg_data[0];
        REG_PROP_GAIN:  prop_gain  <= cfg_data;
        REG_INT_GAIN:   int_gain   <= cfg_data;
        REG_DERIV_GAIN: deriv_gain <= cfg_data;
        REG_INTEG_MIN:  integ_min  <= cfg_data;
        REG_INTEG_MAX:  integ_max  <= cfg_data;
        REG_DRIVE_MIN:  drive_min  <= cfg_data;
        REG_DRIVE_MAX:  drive_max  <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // sequencer and control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      integ_acc   <= '0;
      last_error  <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      if (state == S_CLAMPO && slot_free) begin
        rsp_valid_q <= 1'b1;
      end else if (rsp_valid_q && rsp_ready) begin
        rsp_valid_q <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (req_valid) begin
            state <= S_SCALE;
          end
        end
        S_SCALE:  state <= S_SWAIT;
        S_SWAIT:  state <= S_SRND;
        S_SRND:   state <= S_ERR;
        S_ERR:    state <= S_MULP;
        S_MULP: begin
          last_error <= err_q;
          state      <= S_MULI;
        end
        S_MULI:   state <= S_MULD;
        S_MULD:   state <= S_QLO;
        S_QLO:    state <= S_QHI;
        S_QHI:    state <= S_QREM;
        S_QREM:   state <= S_INC1;
        S_INC1:   state <= S_INC2;
        S_INC2:   state <= S_INC3;
        S_INC3:   state <= S_INTEG;
        S_INTEG:  state <= S_CLAMPI;
        S_CLAMPI: begin
          integ_acc <= integ_clamp;
          state     <= S_ADDI;
        end
        S_ADDI:   state <= S_ADDD;
        S_ADDD:   state <= S_CLAMPO;
        S_CLAMPO: begin
          if (slot_free) begin
            state <= S_IDLE;
          end
        end
        default:  state <= S_IDLE;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        tgt_q  <= target;
        meas_q <= sensed;
      end
      S_SRND:  smag_q <= rnd_scale[49:16];
      S_ERR:   err_q  <= err_sat;
      S_MULP: begin
        sum_q  <= 33'(err_q) + 33'(last_error);
        diff_q <= 33'(err_q) - 33'(last_error);
      end
      S_MULD: begin
        tmp_q   <= rnd_prop[63:16];
        tmp_neg <= prod.neg;
      end
      S_QLO: begin
        acc_q   <= tmp_neg ? -$signed({2'b00, tmp_q}) : $signed({2'b00, tmp_q});
        qhi_q   <= prod.mag[56:50];
        rem17_q <= prod.mag[16:0];
        isat_q  <= |prod.mag[PROD_W-1:57];
        ineg_q  <= prod.neg;
      end
      S_QHI: begin
        dneg_q <= prod.neg;
        dnum_q <= rnd_deriv[63:16];
      end
      S_QREM:  inc_q  <= prod.mag[INC_W-1:0];
      S_INC1:  inc_q  <= inc_q + {prod.mag[23:0], 33'd0};
      S_INC2:  rr_q   <= rnd_rem[33:17];
      S_INC3:  inc_q  <= inc_q + INC_W'(rr_q);
      S_INTEG: integ_q <= 43'(integ_acc) + integ_inc;
      S_ADDI:  acc_q  <= acc_q + 50'(integ_acc);
      S_ADDD: begin
        acc_q <= dneg_q ? acc_q - $signed({2'b00, div_quo})
                        : acc_q + $signed({2'b00, div_quo});
      end
      S_CLAMPO: begin
        if (slot_free) begin
          if (total > out_hi) begin
            drive_q         <= drive_max;
            drive_clamped_q <= 1'b1;
          end else if (total < out_lo) begin
            drive_q         <= drive_min;
            drive_clamped_q <= 1'b1;
          end else begin
            drive_q         <= total[Q_W-1:0];
            drive_clamped_q <= 1'b0;
          end
        end
      end
      default: begin
      end
    endcase
  end

  assign req_ready     = (state == S_IDLE);
  assign rsp_valid     = rsp_valid_q;
  assign drive         = drive_q;
  assign drive_clamped = drive_clamped_q;

  // a stalled result word holds its payload
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && !rsp_ready) |=>
      (rsp_valid && $stable(drive) && $stable(drive_clamped)))
    else $error("result word changed while stalled");

  // a finished word is loaded only into a free output register
  a_out_load: assert property (@(posedge clk) disable iff (rst)
    (state == S_CLAMPO && slot_free) |=> (rsp_valid && state == S_IDLE))
    else $error("result word not presented after load");

  // a clamped word carries one of the output limits
  a_clamp_val: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && drive_clamped) |-> (drive == drive_max || drive == drive_min))
    else $error("clamped drive is not an output limit");

endmodule

`default_nettype wire

// File: verif/axis_pid_controller_unit_checker.sv
// Checker for the axis PID controller: keeps its own copy of the registers, integrator and
// previous error, predicts drive/drive_clamped for every accepted word and compares them.
// Depends on apc_pkg for port widths and register index names.

module axis_pid_controller_unit_checker
  import apc_pkg::*;
#(
  parameter int SAMPLE_PERIOD = 3000
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  req_valid,
  input  wire logic                  req_ready,
  input  wire logic signed [Q_W-1:0] target,
  input  wire logic signed [Q_W-1:0] sensed,
  input  wire logic                  rsp_valid,
  input  wire logic                  rsp_ready,
  input  wire logic signed [Q_W-1:0] drive,
  input  wire logic                  drive_clamped,
  input  wire logic                  cfg_write,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [Q_W-1:0]        cfg_data,
  input  wire logic                  wrap_up,
  output int                         errors
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef logic [63:0] u64_t;

  typedef struct packed {
    logic signed [Q_W-1:0] drive;
    logic                  clamped;
  } drive_word_t;

  localparam u64_t   DEFAULT_PERIOD = 64'd3000;
  localparam u64_t   PERIOD_EFF     = (SAMPLE_PERIOD == 0) ? DEFAULT_PERIOD :
                                      u64_t'(SAMPLE_PERIOD);
  localparam longint SCALE_NEG      = 62259;   // 0.95
  localparam longint SCALE_POS      = 68813;   // 1.05
  localparam u64_t   INC_CAP        = 64'h100_0000_0000;
  localparam longint WORD_TOP       = 64'sd2147483647;
  localparam longint WORD_BOT       = -64'sd2147483648;
  localparam int     PRINT_CAP      = 100;

  // register copies
  logic                  axis_sel;
  logic signed [Q_W-1:0] gain_p, gain_i, gain_d;
  logic signed [Q_W-1:0] integ_lo, integ_hi, drive_lo, drive_hi;

  // loop state
  longint integ_acc;
  longint prev_error;

  drive_word_t drive_expected[$];
  int          mismatch_count = 0;
  bit          wrapped = 1'b0;

  assign errors = mismatch_count;

  task automatic report_mismatch(input string what);
    if (mismatch_count < PRINT_CAP) $display("[%0t] drive check: %s", $time, what);
    mismatch_count++;
  endtask

  function automatic u64_t mag64(input longint v);
    return (v < 0) ? u64_t'(-v) : u64_t'(v);
  endfunction

  function automatic longint apply_sign(input u64_t m, input bit neg);
    return neg ? -longint'(m) : longint'(m);
  endfunction

  // (a*b)/2^sh, magnitude rounded half away from zero
  function automatic longint mul_shift_round(input longint a, input longint b, input int sh);
    u64_t m;
    m = mag64(a) * mag64(b);
    m = (m + (u64_t'(1) << (sh - 1))) >> sh;
    return apply_sign(m, (a < 0) != (b < 0));
  endfunction

  // one controller step; updates integrator and previous error
  function automatic drive_word_t pid_predict(input logic signed [Q_W-1:0] tgt,
                                              input logic signed [Q_W-1:0] meas);
    longint      t_l, m_l, err, scaled, psum, diff, pterm, iterm, dterm, total, lo, hi;
    longint      ki, kd;
    u64_t        prod, quo, rem, inc, dd;
    drive_word_t res;
    t_l = tgt;
    m_l = meas;
    ki  = gain_i;
    kd  = gain_d;

    // error, saturated to a word
    if (axis_sel == MODE_ROLL) begin
      scaled = mul_shift_round(m_l, (m_l < 0) ? SCALE_NEG : SCALE_POS, 16);
      err = t_l - scaled;
    end else begin
      err = m_l - t_l;
    end
    if (err > WORD_TOP) err = WORD_TOP;
    else if (err < WORD_BOT) err = WORD_BOT;

    pterm = mul_shift_round(longint'(gain_p), err, 16);

    // trapezoidal integrator step with capped increment
    psum = err + prev_error;
    prod = mag64(ki) * mag64(psum);
    quo  = prod >> 17;
    rem  = prod & 64'h1FFFF;
    if (quo >= INC_CAP) inc = INC_CAP;
    else inc = quo * PERIOD_EFF + ((rem * PERIOD_EFF + 64'h10000) >> 17);
    if (inc > INC_CAP) inc = INC_CAP;
    iterm = integ_acc + apply_sign(inc, (ki < 0) != (psum < 0));
    hi = integ_hi;
    lo = integ_lo;
    if (iterm > hi) iterm = hi;
    else if (iterm < lo) iterm = lo;

    // derivative, single rounding over T * 2^16
    diff = err - prev_error;
    prod = mag64(kd) * mag64(diff);
    dd   = PERIOD_EFF << 16;
    prod = (prod + (dd >> 1)) / dd;
    dterm = apply_sign(prod, (kd < 0) != (diff < 0));

    // output clamp: upper limit tested first, hitting a limit exactly is not a clamp
    total = pterm + iterm + dterm;
    hi = drive_hi;
    lo = drive_lo;
    res.clamped = 1'b0;
    if (total > hi) begin
      total = hi;
      res.clamped = 1'b1;
    end else if (total < lo) begin
      total = lo;
      res.clamped = 1'b1;
    end
    res.drive = total[Q_W-1:0];

    integ_acc  = iterm;
    prev_error = err;
    return res;
  endfunction

  // watch config, request and response channels
  always @(posedge clk) begin
    drive_word_t want;
    if (rst) begin
      axis_sel   = MODE_ROLL;
      gain_p     = '0;
      gain_i     = '0;
      gain_d     = '0;
      integ_lo   = '0;
      integ_hi   = '0;
      drive_lo   = '0;
      drive_hi   = '0;
      integ_acc  = 0;
      prev_error = 0;
      drive_expected.delete();
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          REG_AXIS_MODE:  axis_sel = cfg_data[0];
          REG_PROP_GAIN:  gain_p   = cfg_data;
          REG_INT_GAIN:   gain_i   = cfg_data;
          REG_DERIV_GAIN: gain_d   = cfg_data;
          REG_INTEG_MIN:  integ_lo = cfg_data;
          REG_INTEG_MAX:  integ_hi = cfg_data;
          REG_DRIVE_MIN:  drive_lo = cfg_data;
          REG_DRIVE_MAX:  drive_hi = cfg_data;
          default: ;
        endcase
      end

      // older word leaves before a new one is predicted
      if (rsp_valid && rsp_ready) begin
        if (drive_expected.size() == 0) begin
          report_mismatch($sformatf("word with nothing pending: drive=%h clamped=%b",
                                    drive, drive_clamped));
        end else begin
          want = drive_expected.pop_front();
          if (drive !== want.drive)
            report_mismatch($sformatf("drive %h, want %h", drive, want.drive));
          if (drive_clamped !== want.clamped)
            report_mismatch($sformatf("drive_clamped %b, want %b (drive %h)",
                                      drive_clamped, want.clamped, want.drive));
        end
      end

      if (req_valid && req_ready) drive_expected.push_back(pid_predict(target, sensed));

      if (wrap_up && !wrapped) begin
        wrapped = 1'b1;
        while (drive_expected.size() != 0) begin
          want = drive_expected.pop_front();
          report_mismatch($sformatf("word never returned: drive %h", want.drive));
        end
      end
    end
  end

endmodule

// File: verif/axis_pid_controller_unit_tb.sv
// Testbench top for axis_pid_controller_unit: clock, reset, config writes, request words
// with random gaps, random response stalls and the verdict.
// Depends on apc_pkg, the RTL and axis_pid_controller_unit_checker.

module axis_pid_controller_unit_tb;
  import apc_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SAMPLE_PERIOD_T = 3000;
  localparam int ITEM_TARGET     = 850;
  localparam int WATCHDOG_CYCLES = 4000;
  localparam int SMALL_SPAN      = 300 * 65536;   // +-300.0
  localparam int NOISE_SPAN      = 8 * 65536;     // +-8.0
  localparam logic signed [Q_W-1:0] ONE     = 32'sh0001_0000;
  localparam logic signed [Q_W-1:0] FIVE    = 32'sh0005_0000;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  req_valid = 1'b0;
  logic                  req_ready;
  logic signed [Q_W-1:0] target = '0;
  logic signed [Q_W-1:0] sensed = '0;
  logic                  rsp_valid;
  logic                  rsp_ready = 1'b0;
  logic signed [Q_W-1:0] drive;
  logic                  drive_clamped;
  logic                  cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [Q_W-1:0]        cfg_data = '0;
  logic                  wrap_up = 1'b0;
  int                    check_errors;

  int unsigned words_sent = 0;
  int unsigned words_back = 0;
  int unsigned idle_cycles = 0;
  int unsigned ready_left = 0;
  int unsigned calm_items = 0;
  int unsigned items_issued = 0;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  axis_pid_controller_unit #(.SAMPLE_PERIOD(SAMPLE_PERIOD_T)) u_top (
    .clk(clk), .rst(rst),
    .req_valid(req_valid), .req_ready(req_ready), .target(target), .sensed(sensed),
    .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
    .drive(drive), .drive_clamped(drive_clamped),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  axis_pid_controller_unit_checker #(.SAMPLE_PERIOD(SAMPLE_PERIOD_T)) u_checker (
    .clk(clk), .rst(rst),
    .req_valid(req_valid), .req_ready(req_ready), .target(target), .sensed(sensed),
    .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
    .drive(drive), .drive_clamped(drive_clamped),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .wrap_up(wrap_up), .errors(check_errors)
  );

  // mostly short gaps, a few long
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic int unsigned pick_hold();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(0, 6);
    if (r < 95) return $urandom_range(7, 30);
    return $urandom_range(60, 200);
  endfunction

  function automatic logic signed [Q_W-1:0] pick_sample();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r == 0) begin
      case ($urandom_range(0, 4))
        0: return Q_MIN;
        1: return Q_MAX;
        2: return 0;
        3: return -1;
        default: return 1;
      endcase
    end
    if (r < 3) return $urandom();
    return int'($urandom_range(0, 2 * SMALL_SPAN)) - SMALL_SPAN;
  endfunction

  function automatic logic signed [Q_W-1:0] pick_gain();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r == 0) begin
      case ($urandom_range(0, 3))
        0: return Q_MIN;
        1: return Q_MAX;
        2: return 0;
        default: return ONE;
      endcase
    end
    if (r < 3) return $urandom();
    return int'($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000;   // +-4.0
  endfunction

  function automatic void pick_range(output logic signed [Q_W-1:0] lo,
                                     output logic signed [Q_W-1:0] hi);
    int unsigned span;
    case ($urandom_range(0, 7))
      0: begin
        lo = Q_MIN;
        hi = Q_MAX;
      end
      1: begin
        // inverted limits
        hi = -int'($urandom_range(0, 32'h7FFF_FFFF));
        lo = int'($urandom_range(0, 32'h7FFF_FFFF));
      end
      2: begin
        lo = pick_sample();
        hi = lo;
      end
      default: begin
        span = ($urandom_range(0, 3) == 0) ? 32'h7FFF_FFFF : $urandom_range(65536, SMALL_SPAN);
        lo = -int'($urandom_range(0, span));
        hi = int'($urandom_range(0, span));
      end
    endcase
  endfunction

  // response side: random stalls with occasional long ready stretches
  always @(posedge clk) begin
    if (ready_left != 0) begin
      ready_left <= ready_left - 1;
    end else if (rsp_ready) begin
      rsp_ready  <= 1'b0;
      ready_left <= pick_gap();
    end else begin
      rsp_ready  <= 1'b1;
      ready_left <= pick_hold();
    end
  end

  // word counts and watchdog
  always @(posedge clk) begin
    if (req_valid && req_ready) words_sent <= words_sent + 1;
    if (rsp_valid && rsp_ready) words_back <= words_back + 1;
    if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_CYCLES) begin
      $display("axis_pid_controller_unit_tb: errors");
      $finish;
    end
  end

  // returns at the edge that accepts the word, valid still high
  task automatic send_word(input logic signed [Q_W-1:0] tv, input logic signed [Q_W-1:0] sv);
    int unsigned gap;
    gap = (calm_items != 0) ? 0 : pick_gap();
    if (calm_items != 0) calm_items--;
    if (gap != 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_valid <= 1'b1;
    target    <= tv;
    sensed    <= sv;
    do @(negedge clk); while (!req_ready);
    @(posedge clk);
    items_issued++;
  endtask

  // hold off until every word has come back
  task automatic wait_results();
    req_valid <= 1'b0;
    do @(posedge clk); while (words_back != words_sent);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [Q_W-1:0] val);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_write <= 1'b0;
    @(posedge clk);
  endtask

  task automatic load_config(input logic mode,
                             input logic signed [Q_W-1:0] kp, ki, kd,
                             input logic signed [Q_W-1:0] ilo, ihi, dlo, dhi);
    logic [Q_W-1:0] mode_word;
    mode_word    = $urandom();   // upper bits are don't-care
    mode_word[0] = mode;
    write_reg(REG_AXIS_MODE, mode_word);
    write_reg(REG_PROP_GAIN, kp);
    write_reg(REG_INT_GAIN, ki);
    write_reg(REG_DERIV_GAIN, kd);
    write_reg(REG_INTEG_MIN, ilo);
    write_reg(REG_INTEG_MAX, ihi);
    write_reg(REG_DRIVE_MIN, dlo);
    write_reg(REG_DRIVE_MAX, dhi);
  endtask

  initial begin
    logic signed [Q_W-1:0] ilo, ihi, dlo, dhi, setpoint;
    int unsigned           n;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset settings: all limits zero, output lands exactly on them
    send_word(Q_MAX, Q_MIN);
    send_word(0, 0);
    wait_results();

    // roll: error saturation both ways, scaling of either sign
    load_config(MODE_ROLL, ONE, 32'sh0000_8000, 32'sh0002_0000, Q_MIN, Q_MAX, Q_MIN, Q_MAX);
    send_word(Q_MAX, Q_MIN);
    send_word(Q_MIN, Q_MAX);
    send_word(0, -1);
    send_word(0, 1);
    send_word(0, Q_MIN);
    send_word(0, Q_MAX);
    send_word(ONE, ONE);
    send_word(-ONE, -ONE);
    wait_results();

    // pitch: output hitting the limits exactly and just past them
    load_config(MODE_PITCH, ONE, 0, 0, 0, 0, -FIVE, FIVE);
    send_word(0, FIVE);
    send_word(0, FIVE + 1);
    send_word(0, -FIVE);
    send_word(0, -FIVE - 1);
    send_word(Q_MIN, Q_MAX);
    send_word(Q_MAX, Q_MIN);
    wait_results();

    // inverted integrator and output limits, extreme gains, capped increment
    load_config(MODE_ROLL, Q_MIN, Q_MAX, Q_MIN,
                32'sh000A_0000, -32'sh000A_0000, 32'sh0064_0000, -32'sh0064_0000);
    send_word(Q_MAX, Q_MIN);
    send_word(Q_MIN, Q_MAX);
    send_word(0, 0);
    send_word(ONE, -ONE);
    send_word(Q_MIN, Q_MIN);
    wait_results();

    // random settings, each followed by a run of samples around a moving setpoint
    while (items_issued < ITEM_TARGET) begin
      pick_range(ilo, ihi);
      pick_range(dlo, dhi);
      load_config(logic'($urandom_range(0, 1)), pick_gain(), pick_gain(), pick_gain(),
                  ilo, ihi, dlo, dhi);
      n = $urandom_range(25, 70);
      setpoint = pick_sample();
      repeat (n) begin
        if ($urandom_range(0, 9) == 0) setpoint = pick_sample();
        if ($urandom_range(0, 15) == 0) calm_items = $urandom_range(10, 30);
        if ($urandom_range(0, 3) == 0)
          send_word(pick_sample(), pick_sample());
        else
          send_word(setpoint, setpoint + (int'($urandom_range(0, 2 * NOISE_SPAN)) - NOISE_SPAN));
        if ($urandom_range(0, 59) == 0) wait_results();
      end
      wait_results();
    end

    repeat (60) @(posedge clk);
    wrap_up <= 1'b1;
    repeat (2) @(posedge clk);
    if (check_errors == 0) $display("axis_pid_controller_unit_tb: clean");
    else $display("axis_pid_controller_unit_tb: errors");
    $finish;
  end

endmodule

// File: filelist.f
rtl/core/apc_pkg.sv
rtl/core/apc_mul.sv
rtl/core/apc_div.sv
rtl/core/axis_pid_controller_unit.sv
verif/axis_pid_controller_unit_checker.sv
verif/axis_pid_controller_unit_tb.sv
